[rtl/core/fts_pkg.sv]
// fts_pkg: widths, codes and state types for the frame timing statistics block.
// No dependencies; imported by frame_timing_statistics_unit.
`default_nettype none

package fts_pkg;

    localparam int TIME_BITS     = 48;
    localparam int CNT_BITS      = 32;
    localparam int FPS_FRAC_BITS = 8;

    // divider dividend: 64-bit frames*frequency product scaled by the fraction bits
    localparam int DIV_W  = 2 * CNT_BITS + FPS_FRAC_BITS;
    localparam int STEP_W = $clog2(DIV_W);

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CNT_BITS-1:0]  t_count;

    typedef enum logic [1:0] {
        CMD_START         = 2'd0,
        CMD_BEGIN_PRESENT = 2'd1,
        CMD_END_PRESENT   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_STORE
    } t_state;

    typedef enum logic [1:0] {
        OP_FPS,
        OP_FRAME,
        OP_DRAW,
        OP_PRESENT
    } t_div_op;

endpackage

`default_nettype wire

[rtl/core/frame_timing_statistics_unit.sv]
// frame_timing_statistics_unit: windowed frame-time statistics (min/max/avg, fps).
// Depends on fts_pkg for widths, command codes and sequencer types.
`default_nettype none

// Usage
//   Input channel (i_in_valid / o_in_stall): one word = command + 48-bit timestamp.
//   Commands: start, begin-present, end-present; the unused code and every word
//   seen while tick_frequency is zero are taken and dropped.
//   Output channel (o_out_valid / i_out_stall): one word per end-present event,
//   window_done plus the latched metrics.
//   Config channel (i_cfg_valid / o_cfg_ready): writes tick_frequency; always ready,
//   write it only while the block is idle.
// Sequencing
//   Start, begin-present, dropped words: taken while idle, next word the cycle after.
//   End-present that does not close a window: result valid the cycle after accept.
//   End-present that closes a window: a multiply state, then four divisions on the
//   one shared restoring divider (72 steps for fps, 48 for each average, plus a
//   load and a store state per division); result valid after the last store.
//   o_in_stall is high while the sequencer runs and while a result is pending.
// Reset (synchronous, active low): all marks, counts, metrics and tick_frequency
//   clear to zero. A stalled result holds its value until taken.

module frame_timing_statistics_unit
    import fts_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CNT_BITS-1:0]  i_cfg_data,
    // event input
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_command,
    input  wire logic [TIME_BITS-1:0] i_timestamp,
    // result output
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_window_done,
    output logic [CNT_BITS-1:0]       o_frames_total,
    output logic [CNT_BITS-1:0]       o_fps_fixed,
    output logic [TIME_BITS-1:0]      o_avg_frame_ticks,
    output logic [TIME_BITS-1:0]      o_min_frame_ticks,
    output logic [TIME_BITS-1:0]      o_max_frame_ticks,
    output logic [TIME_BITS-1:0]      o_avg_draw_ticks,
    output logic [TIME_BITS-1:0]      o_avg_present_ticks
);

    localparam t_time  TIME_ONES  = '1;
    localparam t_count COUNT_ONES = '1;

    // control
    t_state  r_state, n_state;
    t_div_op r_op, n_op;
    logic    r_out_valid, n_out_valid;
    logic    r_done, n_done;
    t_count  r_freq, n_freq;

    // timing state
    t_time  r_frame_mark, n_frame_mark;
    t_time  r_present_mark, n_present_mark;
    t_time  r_window_mark, n_window_mark;
    t_time  r_last_draw, n_last_draw;
    t_count r_frames, n_frames;
    t_count r_wframes, n_wframes;
    t_time  r_frame_sum, n_frame_sum;
    t_time  r_wmin, n_wmin;
    t_time  r_wmax, n_wmax;
    t_time  r_draw_sum, n_draw_sum;
    t_time  r_present_sum, n_present_sum;

    // latched metrics
    t_count r_lat_total, n_lat_total;
    t_count r_lat_fps, n_lat_fps;
    t_time  r_lat_avg_frame, n_lat_avg_frame;
    t_time  r_lat_min, n_lat_min;
    t_time  r_lat_max, n_lat_max;
    t_time  r_lat_avg_draw, n_lat_avg_draw;
    t_time  r_lat_avg_present, n_lat_avg_present;

    // shared divider and multiply result
    logic [2*CNT_BITS-1:0] r_prod, n_prod;
    logic [DIV_W-1:0]      r_dvd, n_dvd;
    t_time                 r_rem, n_rem;
    t_time                 r_dvsr, n_dvsr;
    logic [STEP_W-1:0]     r_step, n_step;
    t_time                 r_win_len, n_win_len;

    logic                  in_acc;
    t_time                 d_present, d_frame, d_window, d_draw;
    logic [TIME_BITS:0]    sum_frame, sum_draw, sum_present;
    logic [TIME_BITS:0]    trial;
    logic                  trial_ge;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign in_acc      = i_in_valid && !o_in_stall;

    // event arithmetic, modulo the timestamp width
    assign d_present = i_timestamp - r_present_mark;
    assign d_frame   = i_timestamp - r_frame_mark;
    assign d_window  = i_timestamp - r_window_mark;
    assign d_draw    = d_frame;

    assign sum_frame   = {1'b0, r_frame_sum}   + {1'b0, d_frame};
    assign sum_draw    = {1'b0, r_draw_sum}    + {1'b0, r_last_draw};
    assign sum_present = {1'b0, r_present_sum} + {1'b0, d_present};

    // restoring divider step: one compare/subtract per cycle
    assign trial    = {r_rem, r_dvd[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, r_dvsr};

    always_comb begin
        n_state           = r_state;
        n_op              = r_op;
        n_out_valid       = r_out_valid;
        n_done            = r_done;
        n_freq            = r_freq;
        n_frame_mark      = r_frame_mark;
        n_present_mark    = r_present_mark;
        n_window_mark     = r_window_mark;
        n_last_draw       = r_last_draw;
        n_frames          = r_frames;
        n_wframes         = r_wframes;
        n_frame_sum       = r_frame_sum;
        n_wmin            = r_wmin;
        n_wmax            = r_wmax;
        n_draw_sum        = r_draw_sum;
        n_present_sum     = r_present_sum;
        n_lat_total       = r_lat_total;
        n_lat_fps         = r_lat_fps;
        n_lat_avg_frame   = r_lat_avg_frame;
        n_lat_min         = r_lat_min;
        n_lat_max         = r_lat_max;
        n_lat_avg_draw    = r_lat_avg_draw;
        n_lat_avg_present = r_lat_avg_present;
        n_prod            = r_prod;
        n_dvd             = r_dvd;
        n_rem             = r_rem;
        n_dvsr            = r_dvsr;
        n_step            = r_step;
        n_win_len         = r_win_len;

        if (i_cfg_valid && o_cfg_ready) begin
            n_freq = i_cfg_data;
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (r_freq != '0)) begin
                    case (t_cmd'(i_command))
                        CMD_START: begin
                            n_frame_mark      = i_timestamp;
                            n_present_mark    = i_timestamp;
                            n_window_mark     = i_timestamp;
                            n_frames          = '0;
                            n_last_draw       = '0;
                            n_wframes         = '0;
                            n_frame_sum       = '0;
                            n_wmin            = '0;
                            n_wmax            = '0;
                            n_draw_sum        = '0;
                            n_present_sum     = '0;
                            n_lat_total       = '0;
                            n_lat_fps         = '0;
                            n_lat_avg_frame   = '0;
                            n_lat_min         = '0;
                            n_lat_max         = '0;
                            n_lat_avg_draw    = '0;
                            n_lat_avg_present = '0;
                        end
                        CMD_BEGIN_PRESENT: begin
                            n_last_draw    = d_draw;
                            n_present_mark = i_timestamp;
                        end
                        CMD_END_PRESENT: begin
                            n_frames = r_frames + 1'b1;
                            if (r_wframes != COUNT_ONES) begin
                                n_wframes = r_wframes + 1'b1;
                            end
                            n_frame_sum   = sum_frame[TIME_BITS] ? TIME_ONES
                                                                 : sum_frame[TIME_BITS-1:0];
                            n_draw_sum    = sum_draw[TIME_BITS] ? TIME_ONES
                                                                : sum_draw[TIME_BITS-1:0];
                            n_present_sum = sum_present[TIME_BITS] ? TIME_ONES
                                                                   : sum_present[TIME_BITS-1:0];
                            // first frame of a window sets the minimum outright
                            if ((r_wframes == '0) || (d_frame < r_wmin)) begin
                                n_wmin = d_frame;
                            end
                            if (d_frame > r_wmax) begin
                                n_wmax = d_frame;
                            end
                            n_frame_mark = i_timestamp;

                            if (d_window >= TIME_BITS'(r_freq)) begin
                                n_lat_total   = r_frames + 1'b1;
                                n_window_mark = i_timestamp;
                                n_win_len     = d_window;
                                n_op          = OP_FPS;
                                n_state       = ST_MUL;
                            end else begin
                                n_done      = 1'b0;
                                n_out_valid = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_MUL: begin
                n_prod  = r_wframes * r_freq;
                n_state = ST_LOAD;
            end

            ST_LOAD: begin
                n_rem = '0;
                unique case (r_op)
                    OP_FPS: begin
                        n_dvd  = DIV_W'(r_prod) << FPS_FRAC_BITS;
                        n_dvsr = r_win_len;
                        n_step = STEP_W'(DIV_W - 1);
                    end
                    OP_FRAME: begin
                        n_dvd  = DIV_W'(r_frame_sum) << (DIV_W - TIME_BITS);
                        n_dvsr = TIME_BITS'(r_wframes);
                        n_step = STEP_W'(TIME_BITS - 1);
                    end
                    OP_DRAW: begin
                        n_dvd  = DIV_W'(r_draw_sum) << (DIV_W - TIME_BITS);
                        n_dvsr = TIME_BITS'(r_wframes);
                        n_step = STEP_W'(TIME_BITS - 1);
                    end
                    OP_PRESENT: begin
                        n_dvd  = DIV_W'(r_present_sum) << (DIV_W - TIME_BITS);
                        n_dvsr = TIME_BITS'(r_wframes);
                        n_step = STEP_W'(TIME_BITS - 1);
                    end
                    default: begin
                    end
                endcase
                n_state = ST_DIV;
            end

            ST_DIV: begin
                n_rem  = trial_ge ? TIME_BITS'(trial - {1'b0, r_dvsr})
                                  : trial[TIME_BITS-1:0];
                n_dvd  = {r_dvd[DIV_W-2:0], trial_ge};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = ST_STORE;
                end
            end

            ST_STORE: begin
                n_state = ST_LOAD;
                unique case (r_op)
                    OP_FPS: begin
                        n_lat_fps = (r_dvd[DIV_W-1:CNT_BITS] != '0) ? COUNT_ONES
                                                                   : r_dvd[CNT_BITS-1:0];
                        n_op      = OP_FRAME;
                    end
                    OP_FRAME: begin
                        n_lat_avg_frame = r_dvd[TIME_BITS-1:0];
                        n_op            = OP_DRAW;
                    end
                    OP_DRAW: begin
                        n_lat_avg_draw = r_dvd[TIME_BITS-1:0];
                        n_op           = OP_PRESENT;
                    end
                    OP_PRESENT: begin
                        n_lat_avg_present = r_dvd[TIME_BITS-1:0];
                        n_lat_min         = r_wmin;
                        n_lat_max         = r_wmax;
                        n_wframes         = '0;
                        n_frame_sum       = '0;
                        n_wmin            = '0;
                        n_wmax            = '0;
                        n_draw_sum        = '0;
                        n_present_sum     = '0;
                        n_done            = 1'b1;
                        n_out_valid       = 1'b1;
                        n_state           = ST_IDLE;
                    end
                    default: begin
                    end
                endcase
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_op              <= OP_FPS;
            r_out_valid       <= 1'b0;
            r_done            <= 1'b0;
            r_freq            <= '0;
            r_frame_mark      <= '0;
            r_present_mark    <= '0;
            r_window_mark     <= '0;
            r_last_draw       <= '0;
            r_frames          <= '0;
            r_wframes         <= '0;
            r_frame_sum       <= '0;
            r_wmin            <= '0;
            r_wmax            <= '0;
            r_draw_sum        <= '0;
            r_present_sum     <= '0;
            r_lat_total       <= '0;
            r_lat_fps         <= '0;
            r_lat_avg_frame   <= '0;
            r_lat_min         <= '0;
            r_lat_max         <= '0;
            r_lat_avg_draw    <= '0;
            r_lat_avg_present <= '0;
        end else begin
            r_state           <= n_state;
            r_op              <= n_op;
            r_out_valid       <= n_out_valid;
            r_done            <= n_done;
            r_freq            <= n_freq;
            r_frame_mark      <= n_frame_mark;
            r_present_mark    <= n_present_mark;
            r_window_mark     <= n_window_mark;
            r_last_draw       <= n_last_draw;
            r_frames          <= n_frames;
            r_wframes         <= n_wframes;
            r_frame_sum       <= n_frame_sum;
            r_wmin            <= n_wmin;
            r_wmax            <= n_wmax;
            r_draw_sum        <= n_draw_sum;
            r_present_sum     <= n_present_sum;
            r_lat_total       <= n_lat_total;
            r_lat_fps         <= n_lat_fps;
            r_lat_avg_frame   <= n_lat_avg_frame;
            r_lat_min         <= n_lat_min;
            r_lat_max         <= n_lat_max;
            r_lat_avg_draw    <= n_lat_avg_draw;
            r_lat_avg_present <= n_lat_avg_present;
        end
    end

    // divider datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod    <= n_prod;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_dvsr    <= n_dvsr;
        r_step    <= n_step;
        r_win_len <= n_win_len;
    end

    // latched metrics cannot change while a result is pending (input is stalled)
    assign o_out_valid         = r_out_valid;
    assign o_window_done       = r_done;
    assign o_frames_total      = r_lat_total;
    assign o_fps_fixed         = r_lat_fps;
    assign o_avg_frame_ticks   = r_lat_avg_frame;
    assign o_min_frame_ticks   = r_lat_min;
    assign o_max_frame_ticks   = r_lat_max;
    assign o_avg_draw_ticks    = r_lat_avg_draw;
    assign o_avg_present_ticks = r_lat_avg_present;

endmodule

`default_nettype wire
